// ===== design/jse_pkg.sv =====
// Shared types and constants for the JSON string escaper.
package jse_pkg;

  localparam int unsigned MAX_BYTES = 6;   // longest escape: \u00XX
  localparam int unsigned CNT_W     = 3;   // holds 0..MAX_BYTES

  typedef enum logic [1:0] {
    CMD_OPEN  = 2'd0,
    CMD_CHAR  = 2'd1,
    CMD_CLOSE = 2'd2
  } cmd_t;

  localparam logic [7:0] CHR_QUOTE = 8'h22;
  localparam logic [7:0] CHR_BSLASH = 8'h5C;
  localparam logic [7:0] CHR_SLASH = 8'h2F;
  localparam logic [7:0] CHR_U     = 8'h75;
  localparam logic [7:0] CHR_ZERO  = 8'h30;
  localparam logic [7:0] CTRL_LIMIT = 8'd32;

  // Expanded output of one item; bytes[0] goes out first.
  typedef struct packed {
    logic [CNT_W-1:0]               count;
    logic [MAX_BYTES-1:0][7:0]      bytes;
  } enc_t;

endpackage

// ===== design/jse_escape.sv =====
// Combinational escape of one command/byte into up to six output bytes.
module jse_escape (
  input  logic [1:0]   command,
  input  logic [7:0]   data_byte,
  output jse_pkg::enc_t enc
);

  function automatic logic [7:0] hex_digit(input logic [3:0] n);
    logic [7:0] d;
    d = (n < 4'd10) ? (8'h30 + {4'h0, n}) : (8'h57 + {4'h0, n}); // 'a' - 10
    return d;
  endfunction

  logic [7:0] short_code;
  logic       is_short;

  always_comb begin
    is_short   = 1'b1;
    short_code = data_byte;
    case (data_byte) inside
      jse_pkg::CHR_QUOTE, jse_pkg::CHR_BSLASH, jse_pkg::CHR_SLASH: short_code = data_byte;
      8'h08: short_code = 8'h62; // b
      8'h0C: short_code = 8'h66; // f
      8'h0A: short_code = 8'h6E; // n
      8'h0D: short_code = 8'h72; // r
      8'h09: short_code = 8'h74; // t
      default: is_short = 1'b0;
    endcase
  end

  always_comb begin
    enc = '0;
    unique case (command)
      jse_pkg::CMD_OPEN, jse_pkg::CMD_CLOSE: begin
        enc.bytes[0] = jse_pkg::CHR_QUOTE;
        enc.count    = jse_pkg::CNT_W'(1);
      end
      jse_pkg::CMD_CHAR: begin
        if (is_short) begin
          enc.bytes[0] = jse_pkg::CHR_BSLASH;
          enc.bytes[1] = short_code;
          enc.count    = jse_pkg::CNT_W'(2);
        end else if (data_byte < jse_pkg::CTRL_LIMIT) begin
          enc.bytes[0] = jse_pkg::CHR_BSLASH;
          enc.bytes[1] = jse_pkg::CHR_U;
          enc.bytes[2] = jse_pkg::CHR_ZERO;
          enc.bytes[3] = jse_pkg::CHR_ZERO;
          enc.bytes[4] = hex_digit(data_byte[7:4]);
          enc.bytes[5] = hex_digit(data_byte[3:0]);
          enc.count    = jse_pkg::CNT_W'(jse_pkg::MAX_BYTES);
        end else begin
          enc.bytes[0] = data_byte;
          enc.count    = jse_pkg::CNT_W'(1);
        end
      end
      default: enc.count = '0; // reserved command: no output
    endcase
  end

endmodule

// ===== design/jse_serializer.sv =====
// Output shift register: emits an expanded item one byte per word.
module jse_serializer (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          load,
  input  jse_pkg::enc_t enc,
  output logic          free,
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [7:0]    out_tdata,
  output logic          out_tlast
);

  logic [jse_pkg::MAX_BYTES-1:0][7:0] buf_r, buf_nxt;
  logic [jse_pkg::CNT_W-1:0]          rem_r, rem_nxt;
  logic                               out_fire;

  assign out_tvalid = (rem_r != '0);
  assign out_tdata  = buf_r[0];
  assign out_tlast  = (rem_r == jse_pkg::CNT_W'(1));
  assign out_fire   = out_tvalid && out_tready;
  // free when empty or when the final byte leaves this cycle
  assign free       = (rem_r == '0) || (out_tlast && out_tready);

  always_comb begin
    buf_nxt = buf_r;
    rem_nxt = rem_r;
    if (load) begin
      buf_nxt = enc.bytes;
      rem_nxt = enc.count;
    end else if (out_fire) begin
      for (int i = 0; i < jse_pkg::MAX_BYTES - 1; i++) begin
        buf_nxt[i] = buf_r[i+1];
      end
      rem_nxt = rem_r - jse_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= '0;
    end else begin
      rem_r <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    buf_r <= buf_nxt;
  end

  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    rem_r <= jse_pkg::CNT_W'(jse_pkg::MAX_BYTES))
    else $error("remaining count out of range");

  a_load_count: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> rem_r == $past(enc.count))
    else $error("load did not take item byte count");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (out_fire && !load) |=> rem_r == $past(rem_r) - jse_pkg::CNT_W'(1))
    else $error("accepted word not retired");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> free)
    else $error("load while a result is still pending");

endmodule

// ===== design/json_string_escaper_top.sv =====
// Top level of the JSON string escaper: input register, escape logic, output serializer.
//
// Input channel (in_*): one word per item. in_tuser carries the command
// (open string, character, close string), in_tdata the raw character byte.
// Output channel (out_*): one byte of escaped JSON text per word; out_tlast
// marks the final byte produced for each input item.
//
// An accepted word lands in a one-entry input register. From there it is
// escaped combinationally and loaded into a six-byte output shift register,
// which drives out_tdata from a register. Throughput is set by the output
// port at one byte per cycle while the receiver is ready: an item expands
// to one byte for plain bytes and quotes, two for short escapes, six for
// \u00XX escapes. A reserved command code passes through the input register
// and produces nothing. The next item is taken while the current one is
// still draining, so items follow each other with no idle cycles on the
// output while the sender keeps up and no reserved command code lies between
// them. When the receiver stalls, the output holds and the input register
// holds one item; in_tready then drops. Reset (synchronous, active low)
// empties both stages.
module json_string_escaper_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] data_byte
  input  logic [1:0] in_tuser,   // [1:0] command
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic       out_tlast   // last_of_run
);

  logic          hold_vld_r, hold_vld_nxt;
  logic [1:0]    hold_cmd_r;
  logic [7:0]    hold_byte_r;
  logic          ser_free;
  logic          load;
  logic          in_fire;
  jse_pkg::enc_t enc;

  // Input register drains into the serializer whenever the latter frees up.
  assign load      = hold_vld_r && ser_free;
  assign in_tready = !hold_vld_r || ser_free;
  assign in_fire   = in_tvalid && in_tready;

  always_comb begin
    hold_vld_nxt = hold_vld_r;
    if (in_fire) begin
      hold_vld_nxt = 1'b1;
    end else if (load) begin
      hold_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_vld_r <= 1'b0;
    end else begin
      hold_vld_r <= hold_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      hold_cmd_r  <= in_tuser;
      hold_byte_r <= in_tdata;
    end
  end

  jse_escape u_escape (
    .command   (hold_cmd_r),
    .data_byte (hold_byte_r),
    .enc       (enc)
  );

  jse_serializer u_serializer (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (load),
    .enc        (enc),
    .free       (ser_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  a_hold_fill: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> hold_vld_r)
    else $error("accepted word not held");

  a_hold_keep: assert property (@(posedge clk) disable iff (!rst_n)
    (hold_vld_r && !load) |=> hold_vld_r && $stable(hold_cmd_r) && $stable(hold_byte_r))
    else $error("held item lost or changed before load");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !hold_vld_r |-> in_tready)
    else $error("input stalled with empty input register");

endmodule

// ===== dv/testbench.sv =====
// Testbench for the JSON string escaper: directed, random and stall tests against a predictor.
`timescale 1ns / 1ps

module testbench;

  localparam logic [1:0] CMD_RESERVED = 2'd3;   // unused code, block drops it
  localparam logic [7:0] CHR_BS  = 8'h08;
  localparam logic [7:0] CHR_TAB = 8'h09;
  localparam logic [7:0] CHR_LF  = 8'h0A;
  localparam logic [7:0] CHR_FF  = 8'h0C;
  localparam logic [7:0] CHR_CR  = 8'h0D;
  localparam int STALL_LIMIT  = 2000;  // cycles with no word moving on either side
  localparam int DRAIN_CYCLES = 8;
  localparam int LONG_HOLD    = 80;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       run_end;
  } json_char_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = '0;
  logic [1:0] in_tuser = '0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic       out_tlast;

  json_char_t escaped_q[$];   // escaped bytes still owed by the block
  int mismatches    = 0;
  int string_items  = 0;
  int dropped_items = 0;
  int long_escapes  = 0;
  int out_words     = 0;
  int quiet_cycles  = 0;
  int rx_hold_cycles = 0;     // nonzero asks the receiver for one long hold-off
  bit tx_idle_en = 1'b1;
  bit rx_idle_en = 1'b1;

  json_string_escaper_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always #6 clk = ~clk;

  function automatic logic [7:0] hex_digit(input logic [3:0] nib);
    return (nib < 4'd10) ? 8'("0") + 8'(nib) : 8'("a") + 8'(nib) - 8'd10;
  endfunction

  // Expected escaped text for one item, queued byte by byte.
  function automatic void predict_escape(input logic [1:0] cmd, input logic [7:0] ch);
    logic [7:0] seq [6];
    int n;
    n = 0;
    case (cmd)
      jse_pkg::CMD_OPEN, jse_pkg::CMD_CLOSE: begin
        seq[0] = jse_pkg::CHR_QUOTE;
        n = 1;
      end
      jse_pkg::CMD_CHAR: begin
        if (ch == jse_pkg::CHR_QUOTE || ch == jse_pkg::CHR_BSLASH ||
            ch == jse_pkg::CHR_SLASH) begin
          seq[0] = jse_pkg::CHR_BSLASH;
          seq[1] = ch;
          n = 2;
        end else if (ch < jse_pkg::CTRL_LIMIT) begin
          seq[0] = jse_pkg::CHR_BSLASH;
          n = 2;
          case (ch)
            CHR_BS:  seq[1] = "b";
            CHR_FF:  seq[1] = "f";
            CHR_LF:  seq[1] = "n";
            CHR_CR:  seq[1] = "r";
            CHR_TAB: seq[1] = "t";
            default: begin
              seq[1] = jse_pkg::CHR_U;
              seq[2] = jse_pkg::CHR_ZERO;
              seq[3] = jse_pkg::CHR_ZERO;
              seq[4] = hex_digit(ch[7:4]);
              seq[5] = hex_digit(ch[3:0]);
              n = 6;
            end
          endcase
        end else begin
          seq[0] = ch;   // printable, DEL and high bytes go through as is
          n = 1;
        end
      end
      default: n = 0;  // reserved code
    endcase
    for (int k = 0; k < n; k++)
      escaped_q.push_back('{seq[k], (k == n - 1)});
    if (n == 6)
      long_escapes++;
    if (n == 0)
      dropped_items++;
    else
      string_items++;
  endfunction

  // Random string byte, weighted toward the escape classes.
  function automatic logic [7:0] pick_char();
    case ($urandom_range(0, 9))
      0, 1, 2: return 8'($urandom_range(32, 126));
      3, 4:    return 8'($urandom_range(0, 31));
      5:       return CHR_BS + 8'($urandom_range(0, 5));   // short-escape neighborhood
      6: begin
        case ($urandom_range(0, 2))
          0:       return jse_pkg::CHR_QUOTE;
          1:       return jse_pkg::CHR_BSLASH;
          default: return jse_pkg::CHR_SLASH;
        endcase
      end
      7:       return 8'h7F;
      default: return 8'($urandom_range(128, 255));
    endcase
  endfunction

  // Offers one word and returns at the edge where it is taken.
  task automatic send_word(input logic [1:0] cmd, input logic [7:0] ch);
    if (tx_idle_en && $urandom_range(0, 2) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= ch;
    do @(posedge clk); while (!in_tready);
    predict_escape(cmd, ch);
  endtask

  // Drops valid and waits for every owed byte, plus the pipeline depth.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (escaped_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic test_directed();
    logic [7:0] specials [] = '{jse_pkg::CHR_QUOTE, jse_pkg::CHR_BSLASH, jse_pkg::CHR_SLASH,
                                CHR_BS, CHR_FF, CHR_LF, CHR_CR, CHR_TAB, 8'h00, 8'h1F,
                                8'h1B, 8'h20, "A", 8'h7F, 8'h80, 8'hFF};
    send_word(jse_pkg::CMD_OPEN, 8'h00);
    foreach (specials[i])
      send_word(jse_pkg::CMD_CHAR, specials[i]);
    send_word(jse_pkg::CMD_CLOSE, 8'hFF);
    // open/close ignore the data byte
    send_word(jse_pkg::CMD_OPEN, 8'hFF);
    send_word(jse_pkg::CMD_CLOSE, 8'h0A);
    // reserved code must produce nothing
    send_word(CMD_RESERVED, 8'h0A);
    send_word(CMD_RESERVED, 8'hFF);
    send_word(jse_pkg::CMD_CHAR, 8'h01);
  endtask

  // Mostly well-formed strings; some stray words and reserved codes mixed in.
  task automatic test_random_strings(input int target);
    int sent;
    int len;
    sent = 0;
    while (sent < target) begin
      tx_idle_en = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 9))
        0: send_word(CMD_RESERVED, 8'($urandom()));
        1: begin
          // broken framing: lone close, lone open or a stray character
          send_word(2'($urandom_range(0, 2)), 8'($urandom()));
          sent++;
        end
        default: begin
          len = $urandom_range(0, 10);
          send_word(jse_pkg::CMD_OPEN, 8'($urandom()));
          repeat (len) send_word(jse_pkg::CMD_CHAR, pick_char());
          send_word(jse_pkg::CMD_CLOSE, 8'($urandom()));
          sent += len + 2;
        end
      endcase
    end
    tx_idle_en = 1'b1;
  endtask

  // Receiver holds off while escaped control characters keep coming, so in_tready must drop.
  task automatic test_output_backpressure();
    rx_hold_cycles = LONG_HOLD;
    send_word(jse_pkg::CMD_OPEN, 8'h00);
    repeat (18) send_word(jse_pkg::CMD_CHAR, 8'($urandom_range(0, 31)));
    send_word(jse_pkg::CMD_CLOSE, 8'h00);
  endtask

  task automatic test_sender_pause();
    send_word(jse_pkg::CMD_OPEN, 8'h00);
    send_word(jse_pkg::CMD_CHAR, 8'h1E);
    send_word(jse_pkg::CMD_CHAR, jse_pkg::CHR_QUOTE);
    wait_drained();
    send_word(jse_pkg::CMD_CHAR, 8'h7E);
    send_word(jse_pkg::CMD_CLOSE, 8'h00);
  endtask

  // No idling on either side: back-to-back items of mixed length.
  task automatic test_full_rate();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    send_word(jse_pkg::CMD_OPEN, 8'($urandom()));
    repeat (36) send_word(jse_pkg::CMD_CHAR, pick_char());
    send_word(CMD_RESERVED, 8'($urandom()));
    send_word(jse_pkg::CMD_CLOSE, 8'($urandom()));
  endtask

  // Receiver: random stall bursts, an optional long hold-off, otherwise ready.
  initial begin
    forever begin
      @(posedge clk);
      if (rx_hold_cycles > 0) begin
        out_tready <= 1'b0;
        repeat (rx_hold_cycles - 1) @(posedge clk);
        rx_hold_cycles = 0;
      end else if (rx_idle_en && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 4) - 1) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Compare each output word with the oldest owed byte.
  always @(posedge clk) begin
    json_char_t want;
    if (rst_n && out_tvalid && out_tready) begin
      out_words++;
      if (escaped_q.size() == 0) begin
        $error("unexpected word: out_tdata=%h out_tlast=%b", out_tdata, out_tlast);
        mismatches++;
      end else begin
        want = escaped_q.pop_front();
        if (out_tdata !== want.text_byte) begin
          $error("out_byte: expected %h, got %h", want.text_byte, out_tdata);
          mismatches++;
        end
        if (out_tlast !== want.run_end) begin
          $error("last_of_run: expected %b, got %b", want.run_end, out_tlast);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: ends a run that stops moving.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random_strings(180);
    test_output_backpressure();
    test_sender_pause();
    test_full_rate();
    wait_drained();
    if (escaped_q.size() != 0) begin
      $error("%0d expected bytes never arrived", escaped_q.size());
      mismatches++;
    end
    $display("Covered %0d string items and %0d reserved-code items, %0d output words",
             string_items, dropped_items, out_words);
    $display("including %0d \\u00XX escapes, stall bursts and a %0d-cycle hold-off",
             long_escapes, LONG_HOLD);
    if (mismatches == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
